FILE: src/mwq_pkg.sv
package mwq_pkg;

	localparam int ID_W   = 16;
	localparam int WAIT_W = 16;
	localparam int STAT_W = 2;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [WAIT_W-1:0] wait_t;
	typedef logic [STAT_W-1:0] stat_t;

	// Operation codes carried on the opcode field.
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// Result status codes.
	localparam stat_t STAT_DONE  = 2'd0;
	localparam stat_t STAT_FULL  = 2'd1;
	localparam stat_t STAT_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take the input beat
		logic scan_init;   // start a maximum search at the head
		logic rd;          // read the slot under the index, advance the index
		logic cmp;         // compare returning read data against the best so far
		logic shift_init;  // point the index just past the best entry
		logic shift_wr;    // write returning read data one slot back
		logic tail_dec;    // drop the last live slot
		logic load_out;    // move the finished result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_extract;
		logic empty;
		logic idx_last;
		logic best_last;
		logic out_free;
	} sts_t;

endpackage

FILE: src/max_wait_extract_queue.sv
// Channel  Handshake            Payload                               Direction
// in       in_valid / in_stall  opcode, process_id, wait_time         into block
// out      out_valid / out_stall status, removed_id, removed_wait     out of block
//
// An insert passes from its input beat through the done state into the output register.
// An extract over the live entries runs one pass of store reads that finds the maximum,
// then, unless the winner is the last entry, a second pass of reads and writes that
// closes the gap.
// Reset clears the tail and the handshake state at once; the store needs no clearing.
// A finished result waits in the output register while the next input beat is taken.
module max_wait_extract_queue import mwq_pkg::*; #(
	parameter int SLOTS = 128
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  opcode,
	input  id_t   process_id,
	input  wait_t wait_time,
	output logic  out_valid,
	input  logic  out_stall,
	output stat_t status,
	output id_t   removed_id,
	output wait_t removed_wait
);

	// The controller sequences the insert, the maximum search and the gap shift.
	// The datapath holds the store, the tail, the scan index, the best entry so
	// far and the output register.
	cmd_t cmd;
	sts_t sts;

	mwq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	mwq_datapath #(
		.SLOTS(SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.process_id  (process_id),
		.wait_time   (wait_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.removed_id  (removed_id),
		.removed_wait(removed_wait)
	);

endmodule

FILE: src/mwq_ram.sv
module mwq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/mwq_ctrl.sv
module mwq_ctrl import mwq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_DRAIN,
		S_SHIFT_INIT,
		S_SHIFT,
		S_SHIFT_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept    = in_valid;
				cmd.scan_init = in_valid && sts.is_extract && !sts.empty;
				if (in_valid) begin
					state_d = (sts.is_extract && !sts.empty) ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				cmd.rd  = 1'b1;
				cmd.cmp = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SCAN_DRAIN;
				end
			end
			S_SCAN_DRAIN: begin
				cmd.cmp = 1'b1;
				state_d = S_SHIFT_INIT;
			end
			S_SHIFT_INIT: begin
				cmd.shift_init = 1'b1;
				cmd.tail_dec   = sts.best_last;
				state_d        = sts.best_last ? S_DONE : S_SHIFT;
			end
			S_SHIFT: begin
				cmd.rd       = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SHIFT_DRAIN;
				end
			end
			S_SHIFT_DRAIN: begin
				cmd.shift_wr = 1'b1;
				cmd.tail_dec = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				cmd.load_out = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/mwq_datapath.sv
module mwq_datapath import mwq_pkg::*; #(
	parameter int SLOTS = 128
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output sts_t  sts,
	input  logic  opcode,
	input  id_t   process_id,
	input  wait_t wait_time,
	output logic  out_valid,
	input  logic  out_stall,
	output stat_t status,
	output id_t   removed_id,
	output wait_t removed_wait
);

	localparam int AW = $clog2(SLOTS);

	logic [AW-1:0] tail_q;
	logic [AW-1:0] idx_q;
	logic          pend_s1;
	logic [AW-1:0] pidx_s1;
	logic [AW-1:0] best_idx_q;
	id_t           best_id_q;
	wait_t         best_wait_q;
	logic          best_vld_q;
	stat_t         res_status_q;
	logic          res_ext_q;
	logic          out_valid_q;
	stat_t         out_status_q;
	id_t           out_id_q;
	wait_t         out_wait_q;

	logic [AW-1:0]          tail_last;
	logic                   full;
	logic                   ins_wr;
	logic                   mem_wr_en;
	logic [AW-1:0]          mem_wr_addr;
	logic [ID_W+WAIT_W-1:0] mem_wr_data;
	logic [ID_W+WAIT_W-1:0] mem_rd_data;
	id_t                    rd_id;
	wait_t                  rd_wait;

	assign tail_last = tail_q - AW'(1);
	assign full      = (tail_q == AW'(SLOTS - 1));

	assign sts.is_extract = (opcode == OP_EXTRACT);
	assign sts.empty      = (tail_q == '0);
	assign sts.idx_last   = (idx_q == tail_last);
	assign sts.best_last  = (best_idx_q == tail_last);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// An insert writes at the tail; the shift writes returning data one slot back.
	assign ins_wr      = cmd.accept && (opcode == OP_INSERT) && !full;
	assign mem_wr_en   = ins_wr || (cmd.shift_wr && pend_s1);
	assign mem_wr_addr = ins_wr ? tail_q : (pidx_s1 - AW'(1));
	assign mem_wr_data = ins_wr ? {process_id, wait_time} : mem_rd_data;

	assign rd_id   = mem_rd_data[ID_W+WAIT_W-1:WAIT_W];
	assign rd_wait = mem_rd_data[WAIT_W-1:0];

	mwq_ram #(
		.WIDTH(ID_W + WAIT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (cmd.rd),
		.rd_addr(idx_q),
		.rd_data(mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q       <= '0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			best_vld_q   <= 1'b0;
			res_status_q <= STAT_DONE;
			res_ext_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			pend_s1 <= cmd.rd;
			if (cmd.accept) begin
				if (opcode == OP_INSERT) begin
					res_status_q <= full ? STAT_FULL : STAT_DONE;
					res_ext_q    <= 1'b0;
					if (!full) begin
						tail_q <= tail_q + AW'(1);
					end
				end else begin
					res_status_q <= sts.empty ? STAT_EMPTY : STAT_DONE;
					res_ext_q    <= !sts.empty;
				end
			end
			if (cmd.scan_init) begin
				idx_q      <= '0;
				best_vld_q <= 1'b0;
			end else if (cmd.shift_init) begin
				idx_q <= best_idx_q + AW'(1);
			end else if (cmd.rd) begin
				idx_q <= idx_q + AW'(1);
			end
			// Strictly greater keeps the earliest entry on a tie.
			if (cmd.cmp && pend_s1 && (!best_vld_q || (rd_wait > best_wait_q))) begin
				best_vld_q <= 1'b1;
			end
			if (cmd.tail_dec) begin
				tail_q <= tail_last;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q;
		if (cmd.cmp && pend_s1 && (!best_vld_q || (rd_wait > best_wait_q))) begin
			best_idx_q  <= pidx_s1;
			best_id_q   <= rd_id;
			best_wait_q <= rd_wait;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_ext_q ? best_id_q : '0;
			out_wait_q   <= res_ext_q ? best_wait_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign removed_id   = out_id_q;
	assign removed_wait = out_wait_q;

	a_tail_range: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= AW'(SLOTS - 1))
		else $error("tail beyond the last usable slot");

	a_wr_inside: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (mem_wr_addr <= tail_q))
		else $error("store write past the tail");

	a_tail_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (tail_q == $past(tail_q) || tail_q == $past(tail_q) + AW'(1)
			|| tail_q == $past(tail_q) - AW'(1)))
		else $error("tail moved by more than one slot");

endmodule
